/* rtl/nscc_pkg.sv */
`timescale 1ns / 1ps
// nscc_pkg: shared types, NAL type constants and the header classifier
// for the NAL start code classifier. No dependencies.
package nscc_pkg;

   localparam int BYTE_W = 8;
   localparam int RUN_W  = 2;

   localparam logic [RUN_W-1:0] RUN_SAT = 2'd2;

   localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_ONE  = 8'h01;

   localparam logic [4:0] H264_PIC_MIN = 5'd1;
   localparam logic [4:0] H264_PIC_MAX = 5'd5;
   localparam logic [4:0] H264_IDR     = 5'd5;

   localparam logic [5:0] H265_PIC_MAX = 6'd31;
   localparam logic [5:0] H265_KEY_MIN = 6'd16;
   localparam logic [5:0] H265_KEY_MAX = 6'd23;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              sample_end;
   } beat_type;

   typedef struct packed {
      logic has_picture;
      logic has_keyframe;
   } flags_type;

   function automatic flags_type classify_header(logic h265, logic [BYTE_W-1:0] b);
      logic [5:0] t265;
      logic [4:0] t264;
      flags_type  f;
      t265 = b[6:1];
      t264 = b[4:0];
      if (h265) begin
         f.has_picture  = (t265 <= H265_PIC_MAX);
         f.has_keyframe = (t265 >= H265_KEY_MIN) && (t265 <= H265_KEY_MAX);
      end else begin
         f.has_picture  = (t264 >= H264_PIC_MIN) && (t264 <= H264_PIC_MAX);
         f.has_keyframe = (t264 == H264_IDR);
      end
      return f;
   endfunction

endpackage

/* rtl/nscc_scan.sv */
`timescale 1ns / 1ps
// nscc_scan: zero-run tracker, header detection and sticky picture/keyframe flags.
// Depends on nscc_pkg.
module nscc_scan (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  nscc_pkg::beat_type  beat,
   input  logic                codec_is_h265,
   output nscc_pkg::flags_type flags
);
   import nscc_pkg::*;

   logic [RUN_W-1:0] zero_run_ff, zero_run_in;
   logic             hdr_exp_ff, hdr_exp_in;
   logic             pic_ff, pic_in;
   logic             key_ff, key_in;
   flags_type        cls;
   flags_type        acc;

   always_comb begin
      cls              = classify_header(codec_is_h265, beat.data_byte);
      acc.has_picture  = pic_ff | (hdr_exp_ff & cls.has_picture);
      acc.has_keyframe = key_ff | (hdr_exp_ff & cls.has_keyframe);
      flags            = acc;
   end

   always_comb begin
      zero_run_in = zero_run_ff;
      hdr_exp_in  = hdr_exp_ff;
      pic_in      = pic_ff;
      key_in      = key_ff;
      if (fire) begin
         pic_in = acc.has_picture;
         key_in = acc.has_keyframe;
         if (beat.data_byte == BYTE_ZERO) begin
            if (zero_run_ff < RUN_SAT) begin
               zero_run_in = zero_run_ff + RUN_W'(1);
            end
            hdr_exp_in = 1'b0;
         end else if ((beat.data_byte == BYTE_ONE) && (zero_run_ff >= RUN_SAT)) begin
            hdr_exp_in  = 1'b1;
            zero_run_in = '0;
         end else begin
            hdr_exp_in  = 1'b0;
            zero_run_in = '0;
         end
         if (beat.sample_end) begin
            zero_run_in = '0;
            hdr_exp_in  = 1'b0;
            pic_in      = 1'b0;
            key_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_run_ff <= '0;
         hdr_exp_ff  <= 1'b0;
         pic_ff      <= 1'b0;
         key_ff      <= 1'b0;
      end else begin
         zero_run_ff <= zero_run_in;
         hdr_exp_ff  <= hdr_exp_in;
         pic_ff      <= pic_in;
         key_ff      <= key_in;
      end
   end

endmodule

/* rtl/nscc_out_reg.sv */
`timescale 1ns / 1ps
// nscc_out_reg: result register on the rsp_ channel, holds a beat while stalled.
// Depends on nscc_pkg.
module nscc_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  nscc_pkg::flags_type flags,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic                rsp_has_picture,
   output logic                rsp_has_keyframe,
   output logic                free
);
   import nscc_pkg::*;

   logic      valid_ff, valid_in;
   flags_type data_ff, data_in;

   always_comb begin
      free     = !valid_ff || !rsp_stall;
      valid_in = load ? 1'b1 : (valid_ff && rsp_stall);
      data_in  = load ? flags : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_has_picture  = data_ff.has_picture;
   assign rsp_has_keyframe = data_ff.has_keyframe;

endmodule

/* rtl/nal_start_code_classifier_core.sv */
`timescale 1ns / 1ps
// nal_start_code_classifier_core: top level of the NAL start code classifier.
// The result of a last-byte beat passes through the input register, then the result register, on its way to rsp_.
// Throughput: one byte per cycle; the input register and the result register
// decouple the channels, so only a stalled result on a last byte holds req_.
// Reset (synchronous, active high) clears the scan state, codec select and valids.
// Depends on nscc_pkg, nscc_scan and nscc_out_reg.
module nal_start_code_classifier_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_sample_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_has_picture,
   output logic       rsp_has_keyframe,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import nscc_pkg::*;

   logic      codec_ff, codec_in;
   logic      s1_valid_ff, s1_valid_in;
   beat_type  s1_beat_ff, s1_beat_in;
   logic      req_accept;
   logic      s1_fire;
   logic      out_free;
   flags_type flags;

   always_comb begin
      codec_in    = csr_wr_en ? csr_wr_data : codec_ff;
      s1_fire     = s1_valid_ff && (!s1_beat_ff.sample_end || out_free);
      req_stall   = s1_valid_ff && !s1_fire;
      req_accept  = req_valid && !req_stall;
      s1_valid_in = req_accept || (s1_valid_ff && !s1_fire);
      s1_beat_in  = s1_beat_ff;
      if (req_accept) begin
         s1_beat_in.data_byte  = req_data_byte;
         s1_beat_in.sample_end = req_sample_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codec_ff    <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         codec_ff    <= codec_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_beat_ff <= s1_beat_in;
   end

   nscc_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .fire          (s1_fire),
      .beat          (s1_beat_ff),
      .codec_is_h265 (codec_ff),
      .flags         (flags)
   );

   nscc_out_reg u_out (
      .clock            (clock),
      .reset            (reset),
      .load             (s1_fire && s1_beat_ff.sample_end),
      .flags            (flags),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_has_picture  (rsp_has_picture),
      .rsp_has_keyframe (rsp_has_keyframe),
      .free             (out_free)
   );

endmodule

/* rtl/nscc_checker.sv */
`timescale 1ns / 1ps
// nscc_checker: port-level assertions for nal_start_code_classifier_core,
// attached by the bind below. Depends on the top level's ports only.
module nscc_checker (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_has_picture,
   input logic rsp_has_keyframe
);

   a_key_implies_pic: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_has_keyframe || rsp_has_picture))
      else $error("keyframe flagged without picture");

   a_rsp_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_req_open_after_reset: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_has_picture) && $stable(rsp_has_keyframe)))
      else $error("stalled result beat changed");

endmodule

bind nal_start_code_classifier_core nscc_checker u_nscc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_has_picture  (rsp_has_picture),
   .rsp_has_keyframe (rsp_has_keyframe)
);
